>>> design/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

>>> design/dcep_pkg.sv
`default_nettype none

package dcep_pkg;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TAG    = 2'd1;
  localparam logic [1:0] PH_LEN    = 2'd2;
  localparam logic [1:0] PH_VALUE  = 2'd3;

  localparam logic [15:0] GROUP_COMMAND   = 16'h0000;
  localparam logic [15:0] ELEM_COMMAND    = 16'h0100;
  localparam logic [15:0] ELEM_MESSAGE_ID = 16'h0110;
  localparam logic [15:0] ELEM_PRIORITY   = 16'h0700;

  localparam logic [2:0] CAT_OTHER = 3'd0;
  localparam logic [2:0] CAT_ECHO  = 3'd1;
  localparam logic [2:0] CAT_STORE = 3'd2;
  localparam logic [2:0] CAT_FIND  = 3'd3;
  localparam logic [2:0] CAT_GET   = 3'd4;
  localparam logic [2:0] CAT_MOVE  = 3'd5;

  localparam logic [14:0] CMD_ECHO  = 15'h0030;
  localparam logic [14:0] CMD_STORE = 15'h0001;
  localparam logic [14:0] CMD_FIND  = 15'h0020;
  localparam logic [14:0] CMD_GET   = 15'h0010;
  localparam logic [14:0] CMD_MOVE  = 15'h0021;

  typedef struct packed {
    logic        found;
    logic [15:0] value;
  } capture_t;

  typedef struct packed {
    logic        status;
    logic [15:0] command_field;
    logic        command_found;
    logic [15:0] message_ident;
    logic        message_found;
    logic [15:0] priority_value;
    logic        priority_found;
    logic        is_response;
    logic [2:0]  category;
  } result_t;

  function automatic logic [2:0] category_of(input logic [15:0] cmd);
    logic [2:0] cat;
    case (cmd[14:0])
      CMD_ECHO:  cat = CAT_ECHO;
      CMD_STORE: cat = CAT_STORE;
      CMD_FIND:  cat = CAT_FIND;
      CMD_GET:   cat = CAT_GET;
      CMD_MOVE:  cat = CAT_MOVE;
      default:   cat = CAT_OTHER;
    endcase
    return cat;
  endfunction

endpackage

`default_nettype wire

>>> design/dicom_command_element_parser_top.sv
// The result word is loaded into the output register when the last byte is accepted.
// Throughput: one byte per cycle while byte_stall is low; the state update between
// input and result register is a single pass, so a new payload may start right
// after the last byte. A byte waits only while a result word is held by result_stall.
// Reset: synchronous, active high; clears parse state, captures and result_valid.
`default_nettype none

`include "assert_macros.svh"

module dicom_command_element_parser_top #(
  parameter int HEADER_BYTES = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             status,
  output logic [15:0]      command_field,
  output logic             command_found,
  output logic [15:0]      message_ident,
  output logic             message_found,
  output logic [15:0]      priority_value,
  output logic             priority_found,
  output logic             is_response,
  output logic [2:0]       category
);

  logic               accept;
  dcep_pkg::result_t  result_next;
  dcep_pkg::result_t  result_q;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  dcep_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .result    (result_next)
  );

  dcep_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && last_byte),
    .result_in    (result_next),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_out   (result_q)
  );

  assign status         = result_q.status;
  assign command_field  = result_q.command_field;
  assign command_found  = result_q.command_found;
  assign message_ident  = result_q.message_ident;
  assign message_found  = result_q.message_found;
  assign priority_value = result_q.priority_value;
  assign priority_found = result_q.priority_found;
  assign is_response    = result_q.is_response;
  assign category       = result_q.category;

  `ASSERT_IMPLY(a_short_clears, clk, rst, result_valid && status, !command_found && !message_found && !priority_found && command_field == 16'd0 && category == dcep_pkg::CAT_OTHER)
  `ASSERT_IMPLY(a_resp_bit, clk, rst, result_valid, is_response == command_field[15])
  `ASSERT_IMPLY(a_unfound_zero, clk, rst, result_valid && !command_found, command_field == 16'd0 && message_found == (message_ident != 16'd0 || message_found))

endmodule

`default_nettype wire

>>> design/dcep_parser.sv
`default_nettype none

module dcep_parser #(
  parameter int HEADER_BYTES = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output dcep_pkg::result_t    result
);

  localparam int CW = $clog2(HEADER_BYTES + 2);
  localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
  localparam logic [1:0] PH_START = (HEADER_BYTES > 0) ? dcep_pkg::PH_HEADER
                                                       : dcep_pkg::PH_TAG;

  logic [CW-1:0]       byte_count, byte_count_next;
  logic [1:0]          phase, phase_next;
  logic [1:0]          field_byte_index, field_byte_index_next;
  logic [31:0]         tag_word, tag_word_next;
  logic [31:0]         value_remaining, value_remaining_next;
  logic                length_ge2, length_ge2_next;
  logic [15:0]         pending_value, pending_value_next;
  dcep_pkg::capture_t  command_reg, command_reg_next;
  dcep_pkg::capture_t  message_reg, message_reg_next;
  dcep_pkg::capture_t  priority_reg, priority_reg_next;
  logic [31:0]         len_full;
  logic [31:0]         rem_dec;
  logic                commit;

  always_comb begin
    byte_count_next       = byte_count;
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    tag_word_next         = tag_word;
    value_remaining_next  = value_remaining;
    length_ge2_next       = length_ge2;
    pending_value_next    = pending_value;
    command_reg_next      = command_reg;
    message_reg_next      = message_reg;
    priority_reg_next     = priority_reg;
    len_full              = {data_byte, value_remaining[23:0]};
    rem_dec               = value_remaining - 32'd1;
    commit                = 1'b0;

    case (phase)
      dcep_pkg::PH_HEADER: begin
        byte_count_next = byte_count + CW'(1);
        if (byte_count_next >= HDR) begin
          phase_next = dcep_pkg::PH_TAG;
        end
      end
      dcep_pkg::PH_TAG: begin
        tag_word_next[8*field_byte_index +: 8] = data_byte;
        field_byte_index_next = field_byte_index + 2'd1;
        if (field_byte_index == 2'd3) begin
          value_remaining_next = '0;
          phase_next = dcep_pkg::PH_LEN;
        end
      end
      dcep_pkg::PH_LEN: begin
        if (field_byte_index == 2'd0) begin
          value_remaining_next = {24'd0, data_byte};
        end else begin
          value_remaining_next[8*field_byte_index +: 8] = data_byte;
        end
        field_byte_index_next = field_byte_index + 2'd1;
        if (field_byte_index == 2'd3) begin
          value_remaining_next = len_full;
          length_ge2_next      = (len_full >= 32'd2);
          pending_value_next   = '0;
          if (len_full == 32'd0) begin
            tag_word_next = '0;
            phase_next    = dcep_pkg::PH_TAG;
          end else begin
            phase_next = dcep_pkg::PH_VALUE;
          end
        end
      end
      default: begin
        if (field_byte_index < 2'd2) begin
          pending_value_next[8*field_byte_index[0] +: 8] = data_byte;
          field_byte_index_next = field_byte_index + 2'd1;
        end
        value_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          commit                = length_ge2 && (tag_word[15:0] == dcep_pkg::GROUP_COMMAND);
          field_byte_index_next = 2'd0;
          tag_word_next         = '0;
          phase_next            = dcep_pkg::PH_TAG;
        end
      end
    endcase

    if (commit) begin
      case (tag_word[31:16])
        dcep_pkg::ELEM_COMMAND:    command_reg_next  = '{1'b1, pending_value_next};
        dcep_pkg::ELEM_MESSAGE_ID: message_reg_next  = '{1'b1, pending_value_next};
        dcep_pkg::ELEM_PRIORITY:   priority_reg_next = '{1'b1, pending_value_next};
        default: ;
      endcase
    end
  end

  always_comb begin
    result = '0;
    if (byte_count_next < HDR) begin
      result.status = 1'b1;
    end else begin
      result.command_field  = command_reg_next.value;
      result.command_found  = command_reg_next.found;
      result.message_ident  = message_reg_next.value;
      result.message_found  = message_reg_next.found;
      result.priority_value = priority_reg_next.value;
      result.priority_found = priority_reg_next.found;
      result.is_response    = command_reg_next.value[15];
      result.category       = dcep_pkg::category_of(command_reg_next.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_count       <= '0;
      phase            <= PH_START;
      field_byte_index <= '0;
      tag_word         <= '0;
      value_remaining  <= '0;
      length_ge2       <= 1'b0;
      pending_value    <= '0;
      command_reg      <= '0;
      message_reg      <= '0;
      priority_reg     <= '0;
    end else if (accept) begin
      byte_count       <= byte_count_next;
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      tag_word         <= tag_word_next;
      value_remaining  <= value_remaining_next;
      length_ge2       <= length_ge2_next;
      pending_value    <= pending_value_next;
      command_reg      <= command_reg_next;
      message_reg      <= message_reg_next;
      priority_reg     <= priority_reg_next;
    end
  end

endmodule

`default_nettype wire

>>> design/dcep_out_reg.sv
`default_nettype none

module dcep_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire dcep_pkg::result_t result_in,
  input  wire logic          result_stall,
  output logic               result_valid,
  output dcep_pkg::result_t  result_out
);

  logic result_valid_next;

  always_comb begin
    if (load) begin
      result_valid_next = 1'b1;
    end else if (result_stall) begin
      result_valid_next = result_valid;
    end else begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HDR_LEN = 6;
  localparam int RANDOM_BYTES = 1620;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        status;
  logic [15:0] command_field;
  logic        command_found;
  logic [15:0] message_ident;
  logic        message_found;
  logic [15:0] priority_value;
  logic        priority_found;
  logic        is_response;
  logic [2:0]  category;

  dicom_command_element_parser_top #(
    .HEADER_BYTES(HDR_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .command_field(command_field),
    .command_found(command_found),
    .message_ident(message_ident),
    .message_found(message_found),
    .priority_value(priority_value),
    .priority_found(priority_found),
    .is_response(is_response),
    .category(category)
  );

  always #1 clk = ~clk;

  // parser state as predicted from the accepted byte stream
  int                  hdr_seen;
  logic [1:0]          phase;
  logic [1:0]          field_idx;
  logic [31:0]         tag_acc;
  logic [31:0]         len_acc;
  logic [31:0]         len_left;
  logic [15:0]         value_acc;
  dcep_pkg::capture_t  cmd_cap;
  dcep_pkg::capture_t  msg_cap;
  dcep_pkg::capture_t  pri_cap;

  dcep_pkg::result_t   expected_summaries[$];
  logic [7:0]  payload[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [3:0]  stall_tick = 4'd0;

  function automatic logic [2:0] service_class(input logic [15:0] cmd);
    logic [14:0] code;
    code = cmd[14:0];
    if (code == dcep_pkg::CMD_ECHO) return dcep_pkg::CAT_ECHO;
    if (code == dcep_pkg::CMD_STORE) return dcep_pkg::CAT_STORE;
    if (code == dcep_pkg::CMD_FIND) return dcep_pkg::CAT_FIND;
    if (code == dcep_pkg::CMD_GET) return dcep_pkg::CAT_GET;
    if (code == dcep_pkg::CMD_MOVE) return dcep_pkg::CAT_MOVE;
    return dcep_pkg::CAT_OTHER;
  endfunction

  task automatic clear_parse_state();
    hdr_seen = 0;
    phase = (HDR_LEN > 0) ? dcep_pkg::PH_HEADER : dcep_pkg::PH_TAG;
    field_idx = 2'd0;
    tag_acc = '0;
    len_acc = '0;
    len_left = '0;
    value_acc = '0;
    cmd_cap = '0;
    msg_cap = '0;
    pri_cap = '0;
  endtask

  task automatic capture_element();
    dcep_pkg::capture_t cap;
    if (len_acc < 32'd2 || tag_acc[15:0] != dcep_pkg::GROUP_COMMAND) return;
    cap.found = 1'b1;
    cap.value = value_acc;
    if (tag_acc[31:16] == dcep_pkg::ELEM_COMMAND) cmd_cap = cap;
    else if (tag_acc[31:16] == dcep_pkg::ELEM_MESSAGE_ID) msg_cap = cap;
    else if (tag_acc[31:16] == dcep_pkg::ELEM_PRIORITY) pri_cap = cap;
  endtask

  task automatic track_payload_byte(input logic [7:0] b, input logic lst);
    int                sh;
    dcep_pkg::result_t r;
    sh = int'(field_idx) * 8;
    case (phase)
      dcep_pkg::PH_HEADER: begin
        if (hdr_seen < HDR_LEN) hdr_seen++;
        if (hdr_seen >= HDR_LEN) phase = dcep_pkg::PH_TAG;
      end
      dcep_pkg::PH_TAG: begin
        tag_acc = tag_acc | (32'(b) << sh);
        field_idx = field_idx + 2'd1;
        if (field_idx == 2'd0) begin
          len_acc = '0;
          phase = dcep_pkg::PH_LEN;
        end
      end
      dcep_pkg::PH_LEN: begin
        len_acc = len_acc | (32'(b) << sh);
        field_idx = field_idx + 2'd1;
        if (field_idx == 2'd0) begin
          len_left = len_acc;
          value_acc = '0;
          if (len_acc == 32'd0) begin
            tag_acc = '0;
            phase = dcep_pkg::PH_TAG;
          end else begin
            phase = dcep_pkg::PH_VALUE;
          end
        end
      end
      default: begin
        if (field_idx < 2'd2) begin
          value_acc = value_acc | (16'(b) << sh);
          field_idx = field_idx + 2'd1;
        end
        len_left = len_left - 32'd1;
        if (len_left == 32'd0) begin
          capture_element();
          field_idx = 2'd0;
          tag_acc = '0;
          phase = dcep_pkg::PH_TAG;
        end
      end
    endcase
    if (!lst) return;
    r = '0;
    if (hdr_seen < HDR_LEN) begin
      r.status = 1'b1;
    end else begin
      r.command_field = cmd_cap.value;
      r.command_found = cmd_cap.found;
      r.message_ident = msg_cap.value;
      r.message_found = msg_cap.found;
      r.priority_value = pri_cap.value;
      r.priority_found = pri_cap.found;
      r.is_response = cmd_cap.value[15];
      r.category = service_class(cmd_cap.value);
    end
    expected_summaries.push_back(r);
    clear_parse_state();
  endtask

  initial clear_parse_state();

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) track_payload_byte(data_byte, last_byte);
  end

  task automatic check_field(input string name, input logic [15:0] exp,
                             input logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    dcep_pkg::result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_summaries.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %b cmd %h",
                 $time, status, command_field);
        errors++;
      end else begin
        e = expected_summaries.pop_front();
        check_field("status", 16'(e.status), 16'(status));
        check_field("command_field", e.command_field, command_field);
        check_field("command_found", 16'(e.command_found), 16'(command_found));
        check_field("message_ident", e.message_ident, message_ident);
        check_field("message_found", 16'(e.message_found), 16'(message_found));
        check_field("priority_value", e.priority_value, priority_value);
        check_field("priority_found", 16'(e.priority_found), 16'(priority_found));
        check_field("is_response", 16'(e.is_response), 16'(is_response));
        check_field("category", 16'(e.category), 16'(category));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    stall_tick <= stall_tick + 4'd1;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= 1'($urandom_range(0, 1));
      2: result_stall <= ($urandom_range(0, 7) != 0);
      default: result_stall <= stall_tick[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = 200;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  task automatic send_payload();
    for (int i = 0; i < payload.size(); i++) send_byte(payload[i], i == payload.size() - 1);
    payload.delete();
  endtask

  task automatic cut_payload(input int n);
    payload = payload[0:n-1];
  endtask

  task automatic put_word16(input logic [15:0] w);
    payload.push_back(w[7:0]);
    payload.push_back(w[15:8]);
  endtask

  task automatic put_header();
    repeat (HDR_LEN) payload.push_back(8'($urandom));
  endtask

  task automatic put_element(input logic [15:0] grp, input logic [15:0] elem,
                             input logic [31:0] len, input logic [15:0] val, input int body);
    put_word16(grp);
    put_word16(elem);
    put_word16(len[15:0]);
    put_word16(len[31:16]);
    for (int i = 0; i < body; i++) begin
      if (i == 0) payload.push_back(val[7:0]);
      else if (i == 1) payload.push_back(val[15:8]);
      else payload.push_back(8'($urandom));
    end
  endtask

  function automatic logic [15:0] pick_command();
    logic resp;
    resp = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0: return {resp, dcep_pkg::CMD_ECHO};
      1: return {resp, dcep_pkg::CMD_STORE};
      2: return {resp, dcep_pkg::CMD_FIND};
      3: return {resp, dcep_pkg::CMD_GET};
      4: return {resp, dcep_pkg::CMD_MOVE};
      5: return 16'($urandom);
      default: return 16'h0000;
    endcase
  endfunction

  task automatic test_short_payloads();
    for (int n = 1; n <= HDR_LEN + 1; n++) begin
      repeat (n) payload.push_back(8'($urandom));
      send_payload();
    end
  endtask

  task automatic test_command_categories();
    logic [15:0] cmds[7];
    cmds = '{{1'b1, dcep_pkg::CMD_ECHO}, {1'b0, dcep_pkg::CMD_STORE},
             {1'b1, dcep_pkg::CMD_FIND}, {1'b0, dcep_pkg::CMD_GET},
             {1'b1, dcep_pkg::CMD_MOVE}, 16'h0000, 16'h7FFF};
    foreach (cmds[i]) begin
      put_header();
      put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, 32'd2, cmds[i], 2);
      send_payload();
    end
  endtask

  task automatic test_all_fields();
    put_header();
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, 32'd4, 16'hFFFF, 4);
    put_element(16'hFFFF, 16'hFFFF, 32'd3, 16'hFFFF, 3);
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_MESSAGE_ID, 32'd2, 16'h0000, 2);
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_PRIORITY, 32'd3, 16'hFFFF, 3);
    send_payload();
  endtask

  task automatic test_special_elements();
    // a repeat overwrites; short values and a foreign group capture nothing
    put_header();
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_MESSAGE_ID, 32'd2, 16'h1234, 2);
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_MESSAGE_ID, 32'd2, 16'hABCD, 2);
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, 32'd0, 16'h0000, 0);
    put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_PRIORITY, 32'd1, 16'h00FF, 1);
    put_element(16'h0008, dcep_pkg::ELEM_COMMAND, 32'd2, 16'h8030, 2);
    send_payload();
    // cut inside tag, length and value
    for (int cut = 0; cut < 3; cut++) begin
      put_header();
      put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_MESSAGE_ID, 32'd2, 16'h5555, 2);
      put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, 32'hFFFF_FFFF,
                  16'h8001, 2);
      cut_payload(HDR_LEN + 10 + 2 + 4 * cut);
      send_payload();
    end
  endtask

  task automatic test_random_payloads();
    int          goal;
    int          pick;
    int          n_elems;
    logic [31:0] len;
    logic [31:0] short_lens[5];
    short_lens = '{32'd0, 32'd1, 32'd3, 32'd4, 32'd6};
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 40)) payload.push_back(8'($urandom));
      end else if (pick < 14) begin
        repeat ($urandom_range(1, HDR_LEN)) payload.push_back(8'($urandom));
      end else begin
        put_header();
        n_elems = $urandom_range(0, 5);
        repeat (n_elems) begin
          len = ($urandom_range(0, 9) < 7) ? 32'd2 : short_lens[$urandom_range(0, 4)];
          case ($urandom_range(0, 9))
            0, 1, 2: put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, len,
                                 pick_command(), len);
            3, 4: put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_MESSAGE_ID, len,
                              16'($urandom), len);
            5, 6: put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_PRIORITY, len,
                              16'($urandom_range(0, 2)), len);
            7: put_element(dcep_pkg::GROUP_COMMAND, 16'($urandom), len, 16'($urandom), len);
            8: put_element(16'($urandom), dcep_pkg::ELEM_COMMAND, len, 16'($urandom), len);
            default: put_element(16'($urandom), 16'($urandom), len, 16'($urandom), len);
          endcase
        end
        if ($urandom_range(0, 4) == 0)
          put_element(dcep_pkg::GROUP_COMMAND, dcep_pkg::ELEM_COMMAND, 32'($urandom),
                      pick_command(), $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0 && payload.size() > 1)
          cut_payload($urandom_range(1, payload.size() - 1));
      end
      send_payload();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_payloads();
    test_command_categories();
    test_all_fields();
    test_special_elements();
    test_random_payloads();
    byte_valid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/dcep_pkg.sv
design/dcep_parser.sv
design/dcep_out_reg.sv
design/dicom_command_element_parser_top.sv
tb/tb_top.sv
